>>> src/rotation_matrix_to_quaternion_unit_defines.svh
// assertion macros shared by the quaternion unit
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define RMQ_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define RMQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> src/rmq_pkg.sv
// shared types and codes for the quaternion unit
`timescale 1ns / 1ps
package rmq_pkg;
	// component slots of the quaternion
	localparam logic [1:0] CX = 2'd0;
	localparam logic [1:0] CY = 2'd1;
	localparam logic [1:0] CZ = 2'd2;
	localparam logic [1:0] CW = 2'd3;

	// per-beat control that rides along the pipeline
	typedef struct packed {
		logic [1:0] sel;  // component that takes the half root
		logic [3:0] neg;  // sign of each numerator
	} rmq_ctl_t;
endpackage

>>> src/rmq_front.sv
// front stage: trace, pivot choice, radicand and numerators
`timescale 1ns / 1ps
module rmq_front #(
	parameter int W = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  logic signed [W-1:0]   m00, m01, m02, m10, m11, m12, m20, m21, m22,
	output logic                  vld_s1,
	output logic [W+1:0]          rad_s1,
	output logic [3:0][W:0]       mag_s1,
	output rmq_pkg::rmq_ctl_t     ctl_s1
);
	import rmq_pkg::*;
	localparam int E = W + 3;
	localparam int F = W - 2;

	logic signed [E-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
	logic signed [E-1:0] one, trace, rad, mx;
	logic signed [E-1:0] num [4];
	logic [1:0] piv;
	rmq_ctl_t ctl;
	logic [3:0][W:0] mag;

	assign e00 = E'(m00);
	assign e01 = E'(m01);
	assign e02 = E'(m02);
	assign e10 = E'(m10);
	assign e11 = E'(m11);
	assign e12 = E'(m12);
	assign e20 = E'(m20);
	assign e21 = E'(m21);
	assign e22 = E'(m22);
	assign one = E'(1) <<< F;
	assign trace = e00 + e11 + e22;

	// largest diagonal, ties to the lower index
	assign mx = (e11 > e00) ? e11 : e00;
	assign piv = (e22 > mx) ? CZ : ((e11 > e00) ? CY : CX);

	// radicand and numerators for each branch, then sign and magnitude
	always_comb begin
		num[0] = '0;
		num[1] = '0;
		num[2] = '0;
		num[3] = '0;
		if (trace > 0) begin
			rad = trace + one;
			ctl.sel = CW;
			num[0] = e21 - e12;
			num[1] = e02 - e20;
			num[2] = e10 - e01;
		end else begin
			ctl.sel = piv;
			unique case (piv)
				CX: begin
					rad = e00 - e11 - e22 + one;
					num[3] = e21 - e12;
					num[1] = e10 + e01;
					num[2] = e20 + e02;
				end
				CY: begin
					rad = e11 - e22 - e00 + one;
					num[3] = e02 - e20;
					num[2] = e21 + e12;
					num[0] = e01 + e10;
				end
				default: begin
					rad = e22 - e00 - e11 + one;
					num[3] = e10 - e01;
					num[0] = e02 + e20;
					num[1] = e12 + e21;
				end
			endcase
			if (rad < 0) begin
				rad = '0;
			end
		end
		for (int l = 0; l < 4; l++) begin
			ctl.neg[l] = num[l][E-1];
			mag[l] = num[l][E-1] ? (W+1)'(0) - num[l][W:0] : num[l][W:0];
		end
	end

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1 <= rad[W+1:0];
			mag_s1 <= mag;
			ctl_s1 <= ctl;
		end
	end
endmodule

>>> src/rmq_sqrt.sv
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
module rmq_sqrt #(
	parameter int W  = 16,
	parameter int SW = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  logic [2*W-1:0] rad,
	input  logic [SW-1:0]  side_in,
	output logic           out_vld,
	output logic [W-1:0]   root,
	output logic [SW-1:0]  side_out
);
	logic [2*W-1:0] v_p    [0:W];
	logic [W+1:0]   rem_p  [0:W];
	logic [W-1:0]   root_p [0:W];
	logic [SW-1:0]  side_p [0:W];
	logic           vld_p  [0:W];

	assign v_p[0] = rad;
	assign rem_p[0] = '0;
	assign root_p[0] = '0;
	assign side_p[0] = side_in;
	assign vld_p[0] = in_vld;

	for (genvar g = 0; g < W; g++) begin : g_stage
		logic [W+1:0] rem_sh, trial;
		logic         ge;

		// bring in the next bit pair and try the next root bit
		assign rem_sh = {rem_p[g][W-1:0], v_p[g][2*W-1:2*W-2]};
		assign trial = {root_p[g], 2'b01};
		assign ge = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_p[g+1] <= 1'b0;
			end else if (en) begin
				vld_p[g+1] <= vld_p[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				v_p[g+1] <= {v_p[g][2*W-3:0], 2'b00};
				rem_p[g+1] <= ge ? rem_sh - trial : rem_sh;
				root_p[g+1] <= {root_p[g][W-2:0], ge};
				side_p[g+1] <= side_p[g];
			end
		end
	end

	assign out_vld = vld_p[W];
	assign root = root_p[W];
	assign side_out = side_p[W];
endmodule

>>> src/rmq_div.sv
// pipelined restoring divider, four lanes over one shared divisor
`timescale 1ns / 1ps
module rmq_div #(
	parameter int W  = 16,
	parameter int SW = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  logic [W:0]            dvsr,
	input  logic [3:0][W:0]       mag,
	input  logic [SW-1:0]         side_in,
	output logic                  out_vld,
	output logic [3:0][2*W-2:0]   quo,
	output logic [SW-1:0]         side_out
);
	localparam int F  = W - 2;
	localparam int DW = 2 * W - 1;

	logic [3:0][DW-1:0] n_p   [0:DW];
	logic [3:0][W:0]    rem_p [0:DW];
	logic [3:0][DW-1:0] q_p   [0:DW];
	logic [W:0]         d_p   [0:DW];
	logic [SW-1:0]      side_p[0:DW];
	logic               vld_p [0:DW];

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			n_p[0][l] = {mag[l], {F{1'b0}}};
			rem_p[0][l] = '0;
			q_p[0][l] = '0;
		end
	end
	assign d_p[0] = dvsr;
	assign side_p[0] = side_in;
	assign vld_p[0] = in_vld;

	for (genvar g = 0; g < DW; g++) begin : g_stage
		logic [3:0][W+1:0] rem_sh;
		logic [3:0]        ge;

		// one quotient bit per lane
		always_comb begin
			for (int l = 0; l < 4; l++) begin
				rem_sh[l] = {rem_p[g][l], n_p[g][l][DW-1]};
				ge[l] = rem_sh[l] >= {1'b0, d_p[g]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_p[g+1] <= 1'b0;
			end else if (en) begin
				vld_p[g+1] <= vld_p[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 4; l++) begin
					n_p[g+1][l] <= {n_p[g][l][DW-2:0], 1'b0};
					rem_p[g+1][l] <= ge[l] ? (W+1)'(rem_sh[l] - {1'b0, d_p[g]})
						: rem_sh[l][W:0];
					q_p[g+1][l] <= {q_p[g][l][DW-2:0], ge[l]};
				end
				d_p[g+1] <= d_p[g];
				side_p[g+1] <= side_p[g];
			end
		end
	end

	assign out_vld = vld_p[DW];
	assign quo = q_p[DW];
	assign side_out = side_p[DW];
endmodule

>>> src/rotation_matrix_to_quaternion_unit.sv
// top level: rotation matrix to quaternion, streaming pipeline
//
// channel  dir  tdata                         tuser
// s_axis   in   m00..m22, W bits each         none
// m_axis   out  qx, qy, qz, qw, W bits each   degenerate
//
// the pipeline holds one front stage, W root stages, 2*W-1 divider stages
// and the output register
// one beat enters every cycle unless m_axis stalls; the long divider chain sets the latency
// reset clears only the valid bits of every stage
// a stall on m_axis freezes the whole pipeline and drops s_axis_tready
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_unit #(
	parameter int ELEMENT_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22, then zero fill
	input  logic [((9*ELEMENT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// qx, qy, qz, qw
	output logic [((4*ELEMENT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	// degenerate
	output logic [0:0] m_axis_tuser
);
	import rmq_pkg::*;
	`include "rotation_matrix_to_quaternion_unit_defines.svh"

	localparam int W   = ELEMENT_WIDTH;
	localparam int DW  = 2 * W - 1;
	localparam int CTW = $bits(rmq_ctl_t);
	localparam int SW1 = CTW + 4 * (W + 1);
	localparam int SW2 = CTW + W;
	localparam int IDW = ((9 * W + 7) / 8) * 8;
	localparam int ODW = ((4 * W + 7) / 8) * 8;
	localparam logic [W-1:0] QMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] QMIN = {1'b1, {(W-1){1'b0}}};

	logic en;
	logic vld_s1, vld_sq, vld_dv;
	logic [W+1:0] rad_s1;
	logic [3:0][W:0] mag_s1, mag_sq;
	rmq_ctl_t ctl_s1, ctl_sq, ctl_dv;
	logic [W-1:0] root_sq, root_dv;
	logic [3:0][DW-1:0] quo;
	logic [W-1:0] comp [4];
	logic [W-1:0] qx_q, qy_q, qz_q, qw_q;
	logic deg_q, vld_q;
	logic [1:0] sel_q;
	logic deg;

	// whole pipeline advances unless the output beat is held
	assign en = !vld_q || m_axis_tready;
	assign s_axis_tready = en;

	rmq_front #(.W(W)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(s_axis_tvalid && en),
		.m00(s_axis_tdata[0*W +: W]), .m01(s_axis_tdata[1*W +: W]),
		.m02(s_axis_tdata[2*W +: W]), .m10(s_axis_tdata[3*W +: W]),
		.m11(s_axis_tdata[4*W +: W]), .m12(s_axis_tdata[5*W +: W]),
		.m20(s_axis_tdata[6*W +: W]), .m21(s_axis_tdata[7*W +: W]),
		.m22(s_axis_tdata[8*W +: W]),
		.vld_s1(vld_s1), .rad_s1(rad_s1), .mag_s1(mag_s1), .ctl_s1(ctl_s1)
	);

	rmq_sqrt #(.W(W), .SW(SW1)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s1),
		.rad({rad_s1, {(W-2){1'b0}}}),
		.side_in({ctl_s1, mag_s1}),
		.out_vld(vld_sq), .root(root_sq), .side_out({ctl_sq, mag_sq})
	);

	rmq_div #(.W(W), .SW(SW2)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_sq),
		.dvsr({root_sq, 1'b0}), .mag(mag_sq),
		.side_in({ctl_sq, root_sq}),
		.out_vld(vld_dv), .quo(quo), .side_out({ctl_dv, root_dv})
	);

	// place the half root, apply the signs and saturate the quotients
	always_comb begin
		for (int l = 0; l < 4; l++) begin
			if (ctl_dv.sel == 2'(l)) begin
				comp[l] = {1'b0, root_dv[W-1:1]};
			end else if (|quo[l][DW-1:W-1]) begin
				comp[l] = ctl_dv.neg[l] ? QMIN : QMAX;
			end else if (ctl_dv.neg[l]) begin
				comp[l] = W'(0) - quo[l][W-1:0];
			end else begin
				comp[l] = quo[l][W-1:0];
			end
		end
	end
	assign deg = (root_dv == '0);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qx_q <= deg ? '0 : comp[0];
			qy_q <= deg ? '0 : comp[1];
			qz_q <= deg ? '0 : comp[2];
			qw_q <= deg ? '0 : comp[3];
			deg_q <= deg;
			sel_q <= ctl_dv.sel;
		end
	end

	assign m_axis_tvalid = vld_q;
	assign m_axis_tdata = ODW'({qw_q, qz_q, qy_q, qx_q});
	assign m_axis_tuser = deg_q;

	// checks on the output stage and on the s_axis_tdata width
	`RMQ_ASSERT_SAME(a_deg_zero, vld_q && deg_q,
		qx_q == '0 && qy_q == '0 && qz_q == '0 && qw_q == '0)
	`RMQ_ASSERT_SAME(a_trace_root, vld_q && sel_q == CW, !deg_q)
	`RMQ_ASSERT_SAME(a_root_sign, vld_q && !deg_q && sel_q == CW, !qw_q[W-1])
	`RMQ_ASSERT_NEXT(a_tdata_width, 1'b1, IDW == $bits(s_axis_tdata))
endmodule
